// ===== hw/rtl/papb_pkg.sv =====
// ----------------------------------------------------------------------------
// papb_pkg
// Shared types, constants and arithmetic helpers of the pixel binner.
// ----------------------------------------------------------------------------
package papb_pkg;

	localparam int PixelCountDef = 4096;
	localparam int AccWidthDef   = 40;
	localparam int PixBits       = 12;
	localparam int HitBits       = 32;
	localparam int CordicSteps   = 16;
	localparam int QueueDepth    = 4;

	localparam logic signed [33:0] CordicGain = 34'sd652032874;
	localparam logic [29:0] QuarterPiQ30 = 30'd843314856;

	typedef enum logic {
		REQ_ACC  = 1'b0,
		REQ_READ = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN
	} back_state_t;

	// Classified request handed from the front to the back.
	typedef struct packed {
		req_kind_t        kind;
		logic             in_range;
		logic [15:0]      angle;
		logic [PixBits-1:0] pixel;
	} work_t;

	function automatic logic signed [33:0] atan_q30(input logic [3:0] i);
		case (i)
			4'd0:  atan_q30 = 34'sd843314856;
			4'd1:  atan_q30 = 34'sd497837829;
			4'd2:  atan_q30 = 34'sd263043836;
			4'd3:  atan_q30 = 34'sd133525158;
			4'd4:  atan_q30 = 34'sd67021686;
			4'd5:  atan_q30 = 34'sd33543515;
			4'd6:  atan_q30 = 34'sd16775850;
			4'd7:  atan_q30 = 34'sd8388437;
			4'd8:  atan_q30 = 34'sd4194282;
			4'd9:  atan_q30 = 34'sd2097149;
			4'd10: atan_q30 = 34'sd1048575;
			4'd11: atan_q30 = 34'sd524287;
			4'd12: atan_q30 = 34'sd262143;
			4'd13: atan_q30 = 34'sd131071;
			4'd14: atan_q30 = 34'sd65535;
			default: atan_q30 = 34'sd32767;
		endcase
	endfunction

	// Round a Q.30-scaled value to Q1.15 and clamp to +-32767.
	function automatic logic signed [16:0] round_q15(input logic signed [33:0] v);
		logic signed [33:0] r;
		r = (v + 34'sd16384) >>> 15;
		if (r > 34'sd32767)
			round_q15 = 17'sd32767;
		else if (r < -34'sd32767)
			round_q15 = -17'sd32767;
		else
			round_q15 = r[16:0];
	endfunction

endpackage

// ===== hw/rtl/papb_front.sv =====
// ----------------------------------------------------------------------------
// papb_front
// Accepts requests, doubles the angle, checks the pixel range, queues work.
// ----------------------------------------------------------------------------
module papb_front import papb_pkg::*; #(
	parameter int PIXEL_COUNT = PixelCountDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [15:0] plate_phase,
	input  logic [15:0] detector_angle,
	input  logic [PixBits-1:0] pixel_index,
	output logic        wk_valid,
	input  logic        wk_ready,
	output work_t       wk_data
);

	localparam int PtrBits = $clog2(QueueDepth);

	work_t             fifo_q [QueueDepth];
	logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
	logic [PtrBits:0]   count_q;
	work_t             item;
	logic              push, pop;
	logic [16:0]       sum;

	always_comb begin
		sum = {1'b0, plate_phase} + {1'b0, detector_angle};
		item.kind     = req_kind_t'(req_type);
		item.angle    = {sum[14:0], 1'b0};
		item.in_range = ({20'd0, pixel_index} < 32'(PIXEL_COUNT));
		item.pixel    = pixel_index;
	end

	assign in_ready = (count_q != (PtrBits+1)'(QueueDepth));
	assign push     = in_valid && in_ready;
	assign wk_valid = (count_q != '0);
	assign pop      = wk_valid && wk_ready;
	assign wk_data  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
		end
	end

endmodule

// ===== hw/rtl/papb_cordic.sv =====
// ----------------------------------------------------------------------------
// papb_cordic
// Iterative rotation: one CORDIC step per cycle, then quadrant mapping.
// ----------------------------------------------------------------------------
module papb_cordic import papb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] angle,
	output logic        done,
	output logic signed [16:0] cos_val,
	output logic signed [16:0] sin_val
);

	logic signed [33:0] x_q, y_q, z_q;
	logic [3:0]         step_q;
	logic               busy_q, done_q;
	logic [1:0]         quad_q;
	logic signed [33:0] dx, dy;
	logic signed [16:0] xc, yc;

	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;
	assign done = done_q;
	assign xc = round_q15(x_q);
	assign yc = round_q15(y_q);

	logic [43:0] prod;
	assign prod = 44'(angle[13:0]) * 44'(QuarterPiQ30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == 4'(CordicSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CordicGain;
			y_q    <= '0;
			z_q    <= 34'(prod >> 13);
			quad_q <= angle[15:14];
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_q30(step_q);
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_q30(step_q);
			end
		end
	end

	always_comb begin
		case (quad_q)
			2'd0: begin cos_val = xc;  sin_val = yc;  end
			2'd1: begin cos_val = -yc; sin_val = xc;  end
			2'd2: begin cos_val = -xc; sin_val = -yc; end
			default: begin cos_val = yc; sin_val = -xc; end
		endcase
	end

endmodule

// ===== hw/rtl/papb_back.sv =====
// ----------------------------------------------------------------------------
// papb_back
// Clears the pixel memory, then runs read-modify-write and read requests.
// ----------------------------------------------------------------------------
module papb_back import papb_pkg::*; #(
	parameter int PIXEL_COUNT = PixelCountDef,
	parameter int ACC_WIDTH   = AccWidthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wk_valid,
	output logic        wk_ready,
	input  work_t       wk_data,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [HitBits-1:0]   hit_total,
	output logic [ACC_WIDTH-1:0] cos_total,
	output logic [ACC_WIDTH-1:0] sin_total,
	output logic [ACC_WIDTH-1:0] cos_sq_total,
	output logic [ACC_WIDTH-1:0] cos_sin_total,
	output logic [ACC_WIDTH-1:0] sin_sq_total
);

	localparam int AddrBits = (PIXEL_COUNT > 4096) ? PixBits : $clog2(PIXEL_COUNT);
	localparam int Depth    = (PIXEL_COUNT > 4096) ? 4096 : PIXEL_COUNT;
	localparam int RowBits  = HitBits + 5 * ACC_WIDTH;
	localparam logic signed [ACC_WIDTH:0] AccMax = (ACC_WIDTH+1)'((65'd1 << (ACC_WIDTH-1)) - 1);
	localparam logic signed [ACC_WIDTH:0] AccMin = -AccMax - 1;

	back_state_t state_q, state_d;
	logic [RowBits-1:0] mem_q [Depth];
	logic [RowBits-1:0] rd_row_q;
	logic [AddrBits:0]  clr_q;
	work_t  job_q;
	logic   [2:0] phase_q;
	logic   cstart, cdone;
	logic signed [16:0] c_val, s_val;
	logic signed [16:0] cc_s1, cs_s1, ss_s1, c_s1, s_s1;
	logic   out_full_q;
	logic   [RowBits-1:0] out_q;
	logic   wr_en;
	logic   [RowBits-1:0] wr_row;

	papb_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cstart), .angle(job_q.angle),
		.done(cdone), .cos_val(c_val), .sin_val(s_val)
	);

	function automatic logic [ACC_WIDTH-1:0] sat(input logic [ACC_WIDTH-1:0] v,
		input logic signed [16:0] t);
		logic signed [ACC_WIDTH:0] r;
		r = $signed({v[ACC_WIDTH-1], v}) + (ACC_WIDTH+1)'(t);
		if (r > AccMax) sat = AccMax[ACC_WIDTH-1:0];
		else if (r < AccMin) sat = AccMin[ACC_WIDTH-1:0];
		else sat = r[ACC_WIDTH-1:0];
	endfunction

	// Phases within a run: 0 start/read, 1 wait rotation and products, 2 and 3 hold, 4 write.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == (AddrBits+1)'(Depth - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (wk_valid) state_d = ST_RUN;
			ST_RUN: begin
				if (job_q.kind == REQ_READ) begin
					if (phase_q == 3'd1 && !out_full_q) state_d = ST_IDLE;
				end else if (!job_q.in_range || phase_q == 3'd4) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		wk_ready = (state_q == ST_IDLE);
		cstart   = (state_q == ST_RUN) && (job_q.kind == REQ_ACC) && (phase_q == 3'd0);
		wr_en    = (state_q == ST_CLEAR) ||
			((state_q == ST_RUN) && job_q.kind == REQ_ACC && job_q.in_range &&
			 phase_q == 3'd4);
	end

	always_comb begin
		logic [HitBits-1:0] h;
		h = rd_row_q[HitBits-1:0];
		if (state_q == ST_CLEAR) begin
			wr_row = '0;
		end else begin
			wr_row = {
				sat(rd_row_q[HitBits+5*ACC_WIDTH-1 -: ACC_WIDTH], ss_s1),
				sat(rd_row_q[HitBits+4*ACC_WIDTH-1 -: ACC_WIDTH], cs_s1),
				sat(rd_row_q[HitBits+3*ACC_WIDTH-1 -: ACC_WIDTH], cc_s1),
				sat(rd_row_q[HitBits+2*ACC_WIDTH-1 -: ACC_WIDTH], s_s1),
				sat(rd_row_q[HitBits+ACC_WIDTH-1 -: ACC_WIDTH], c_s1),
				(h == '1) ? h : h + 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[(state_q == ST_CLEAR) ? clr_q[AddrBits-1:0]
				: job_q.pixel[AddrBits-1:0]] <= wr_row;
		end
		rd_row_q <= mem_q[job_q.pixel[AddrBits-1:0]];
		if (wk_valid && wk_ready) job_q <= wk_data;
		if (cdone) begin
			c_s1  <= c_val;
			s_s1  <= s_val;
			cc_s1 <= round_q15(34'(c_val) * 34'(c_val));
			cs_s1 <= round_q15(34'(c_val) * 34'(s_val));
			ss_s1 <= round_q15(34'(s_val) * 34'(s_val));
		end
		if ((state_q == ST_RUN) && job_q.kind == REQ_READ && phase_q == 3'd1 && !out_full_q)
			out_q <= job_q.in_range ? rd_row_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			phase_q    <= '0;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q != ST_RUN) begin
				phase_q <= '0;
			end else if (job_q.kind == REQ_READ) begin
				if (phase_q == 3'd0) phase_q <= 3'd1;
			end else begin
				case (phase_q)
					3'd0: phase_q <= 3'd1;
					3'd1: if (cdone) phase_q <= 3'd2;
					3'd2: phase_q <= 3'd3;
					3'd3: phase_q <= 3'd4;
					default: phase_q <= 3'd0;
				endcase
			end
			if ((state_q == ST_RUN) && job_q.kind == REQ_READ && phase_q == 3'd1
				&& !out_full_q)
				out_full_q <= 1'b1;
			else if (res_ready)
				out_full_q <= 1'b0;
		end
	end

	assign res_valid     = out_full_q;
	assign hit_total     = out_q[HitBits-1:0];
	assign cos_total     = out_q[HitBits+ACC_WIDTH-1 -: ACC_WIDTH];
	assign sin_total     = out_q[HitBits+2*ACC_WIDTH-1 -: ACC_WIDTH];
	assign cos_sq_total  = out_q[HitBits+3*ACC_WIDTH-1 -: ACC_WIDTH];
	assign cos_sin_total = out_q[HitBits+4*ACC_WIDTH-1 -: ACC_WIDTH];
	assign sin_sq_total  = out_q[HitBits+5*ACC_WIDTH-1 -: ACC_WIDTH];

endmodule

// ===== hw/rtl/polarization_angle_pixel_binner.sv =====
// ----------------------------------------------------------------------------
// polarization_angle_pixel_binner
// Bins detector samples into per-pixel saturating polarization sums.
// ----------------------------------------------------------------------------
// After reset the block sweeps the pixel memory clear, one pixel per cycle;
// meanwhile the front queue takes up to four requests but none is carried
// out. An accumulate request holds the back end from one pickup to the next
// through the 16-step iterative CORDIC rotation, the product stage and the
// read-modify-write of the pixel row; a read holds it while its row is read,
// longer while the previous result still waits in the output register. A
// four-entry queue lets the front take requests while the back end works.
// Pixel indexes at or above PIXEL_COUNT are dropped by accumulates and read
// back as all zero.
module polarization_angle_pixel_binner import papb_pkg::*; #(
	parameter int PIXEL_COUNT = PixelCountDef,
	parameter int ACC_WIDTH   = AccWidthDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// tdata: plate_phase[15:0], detector_angle[31:16], pixel_index[43:32], zero fill
	input  logic [47:0] s_tdata,
	// tuser: req_type
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// tdata: hit_total, cos_total, sin_total, cos_sq_total, cos_sin_total,
	// sin_sq_total from the lowest bit up, zero fill to whole bytes
	output logic [((HitBits + 5*ACC_WIDTH + 7)/8)*8-1:0] m_tdata
);

	localparam int OutBits = HitBits + 5*ACC_WIDTH;
	localparam int OutPad  = ((OutBits + 7)/8)*8;

	logic  wk_valid, wk_ready;
	work_t wk_data;
	logic [HitBits-1:0]   hit_total;
	logic [ACC_WIDTH-1:0] cos_total, sin_total, cos_sq_total, cos_sin_total, sin_sq_total;

	// Classify and queue incoming transfers.
	papb_front #(.PIXEL_COUNT(PIXEL_COUNT)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.req_type(s_tuser), .plate_phase(s_tdata[15:0]),
		.detector_angle(s_tdata[31:16]), .pixel_index(s_tdata[43:32]),
		.wk_valid(wk_valid), .wk_ready(wk_ready), .wk_data(wk_data)
	);

	// Execute requests against the pixel memory.
	papb_back #(.PIXEL_COUNT(PIXEL_COUNT), .ACC_WIDTH(ACC_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.wk_valid(wk_valid), .wk_ready(wk_ready), .wk_data(wk_data),
		.res_valid(m_tvalid), .res_ready(m_tready),
		.hit_total(hit_total), .cos_total(cos_total), .sin_total(sin_total),
		.cos_sq_total(cos_sq_total), .cos_sin_total(cos_sin_total),
		.sin_sq_total(sin_sq_total)
	);

	assign m_tdata = OutPad'({sin_sq_total, cos_sin_total, cos_sq_total, sin_total,
		cos_total, hit_total});

	logic unused_pad;
	assign unused_pad = ^s_tdata[47:44];

	// Hold a stalled result steady.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Never hand work to the back end while it is busy.
	a_work: assert property (@(posedge clk) disable iff (!arst_n)
		wk_ready |=> !wk_ready || !$past(wk_valid))
		else $error("back end took two items back to back");

endmodule

// ===== dv/papb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// papb_checker
// Predicts the pixel sums from the accepted requests and checks every read.
// ----------------------------------------------------------------------------
module papb_checker import papb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [47:0]  s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [231:0] m_tdata,
	output int           failures,
	output int           reads_pending
);

	localparam int NPIX = 4096;
	localparam longint SUM_MAX = (64'sd1 <<< 39) - 1;
	localparam longint SUM_MIN = -SUM_MAX - 1;

	typedef struct {
		logic [31:0] hits;
		logic [39:0] sums [5];
	} pixel_sums_t;

	localparam longint ATAN [16] = '{843314856, 497837829, 263043836, 133525158,
		67021686, 33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
		524287, 262143, 131071, 65535, 32767};

	logic [31:0] hit_mem [NPIX];
	longint      sum_mem [5][NPIX];
	pixel_sums_t sums_due [$];

	assign reads_pending = sums_due.size();

	function automatic longint to_q15(input longint v);
		longint r;
		r = (v + 16384) >>> 15;
		if (r > 32767) r = 32767;
		if (r < -32767) r = -32767;
		return r;
	endfunction

	function automatic longint sat_sum(input longint acc, input longint term);
		if (term > 0 && acc > SUM_MAX - term) return SUM_MAX;
		if (term < 0 && acc < SUM_MIN - term) return SUM_MIN;
		return acc + term;
	endfunction

	// Rotate in the first quadrant, then fold into the quadrant of a[15:14].
	task automatic angle_cos_sin(input logic [15:0] a, output longint c, output longint s);
		longint x, y, z, dx, dy, xr, yr;
		x = 652032874;
		y = 0;
		z = (longint'(a[13:0]) * 843314856) >>> 13;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN[i];
			end else begin
				x += dx; y -= dy; z += ATAN[i];
			end
		end
		xr = to_q15(x);
		yr = to_q15(y);
		case (a[15:14])
			2'd0: begin c = xr;  s = yr;  end
			2'd1: begin c = -yr; s = xr;  end
			2'd2: begin c = -xr; s = -yr; end
			default: begin c = yr;  s = -xr; end
		endcase
	endtask

	task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
		$display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
		failures++;
	endtask

	initial failures = 0;

	always @(posedge clk or negedge arst_n) begin
		logic [15:0] ang;
		logic [11:0] pix;
		longint c, s;
		longint terms [5];
		pixel_sums_t due, got;
		if (!arst_n) begin
			for (int p = 0; p < NPIX; p++) begin
				hit_mem[p] = '0;
				for (int k = 0; k < 5; k++) sum_mem[k][p] = 0;
			end
			sums_due.delete();
		end else begin
			// Check the read result before this edge's request can land.
			if (m_tvalid && m_tready) begin
				got.hits = m_tdata[31:0];
				for (int k = 0; k < 5; k++) got.sums[k] = m_tdata[32+40*k +: 40];
				if (sums_due.size() == 0) begin
					$display("%0t result transfer with no read outstanding", $realtime);
					failures++;
				end else begin
					due = sums_due.pop_front();
					if (got.hits !== due.hits)
						report("hit_total", 40'(got.hits), 40'(due.hits));
					for (int k = 0; k < 5; k++)
						if (got.sums[k] !== due.sums[k])
							report($sformatf("sum field %0d", k), got.sums[k], due.sums[k]);
				end
			end
			if (s_tvalid && s_tready) begin
				pix = s_tdata[43:32];
				if (s_tuser == REQ_ACC) begin
					ang = (s_tdata[15:0] + s_tdata[31:16]) << 1;
					angle_cos_sin(ang, c, s);
					terms = '{c, s, to_q15(c * c), to_q15(c * s), to_q15(s * s)};
					if (hit_mem[pix] != 32'hFFFF_FFFF) hit_mem[pix]++;
					for (int k = 0; k < 5; k++) sum_mem[k][pix] = sat_sum(sum_mem[k][pix], terms[k]);
				end else begin
					due.hits = hit_mem[pix];
					for (int k = 0; k < 5; k++) due.sums[k] = sum_mem[k][pix][39:0];
					sums_due.push_back(due);
				end
			end
		end
	end

endmodule

// ===== dv/tb_polarization_angle_pixel_binner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polarization_angle_pixel_binner
// Streams accumulate and read requests with random gaps and stalls; the
// checker predicts every pixel read and compares it field by field.
// ----------------------------------------------------------------------------
module tb_polarization_angle_pixel_binner import papb_pkg::*; ;

	localparam int CYCLE_LIMIT = 300000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [47:0]  s_tdata;   // plate_phase, detector_angle, pixel_index, zero fill
	logic         s_tuser;   // req_type
	logic         m_tvalid;
	logic         m_tready;
	logic [231:0] m_tdata;   // hit_total then the five sums, 32 + 5 x 40 bits
	int           failures;
	int           reads_pending;
	int           cycles;
	logic         hold_sink; // ask the sink for one long hold-off

	polarization_angle_pixel_binner uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	papb_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.failures(failures), .reads_pending(reads_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Gap length for one transfer; some windows run with no gaps at all.
	function automatic int draw_gap();
		if (cycles[10:9] == 2'd0) return 0;
		return $urandom_range(0, 15);
	endfunction

	// Watchdog: also covers the clearing sweep after reset.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_polarization_angle_pixel_binner failed");
			$finish;
		end
	end

	// Sink: stall at random, once hold off long enough to back the block up.
	initial begin
		int n;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			n = draw_gap();
			if (hold_sink) begin
				n = 400;
				hold_sink = 1'b0;
			end
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Offer one request after a random gap; hold tvalid if the next follows at once.
	task automatic send(input req_kind_t kind, input logic [15:0] phase,
			input logic [15:0] det, input logic [11:0] pix);
		int n;
		n = draw_gap();
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {4'b0, pix, det, phase};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	initial begin
		logic [11:0] pix;
		cycles    = 0;
		hold_sink = 1'b0;
		s_tvalid  = 1'b0;
		s_tuser   = REQ_ACC;
		s_tdata   = '0;
		arst_n    = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: untouched pixels, angle extremes and quadrant edges, read back.
		send(REQ_READ, 16'h0000, 16'h0000, 12'd0);
		send(REQ_READ, 16'hFFFF, 16'hFFFF, 12'd4095);
		send(REQ_ACC, 16'h0000, 16'h0000, 12'd0);
		send(REQ_ACC, 16'hFFFF, 16'hFFFF, 12'd0);
		send(REQ_ACC, 16'h2000, 16'h0000, 12'd0);
		send(REQ_ACC, 16'h0000, 16'h4000, 12'd0);
		send(REQ_ACC, 16'h6000, 16'h0000, 12'd4095);
		send(REQ_ACC, 16'h1FFF, 16'h0000, 12'd4095);
		send(REQ_ACC, 16'h8000, 16'h7FFF, 12'd4095);
		send(REQ_ACC, 16'h5555, 16'hAAAA, 12'd4095);
		send(REQ_ACC, 16'h1000, 16'h0000, 12'd2048);
		send(REQ_ACC, 16'h3000, 16'h0000, 12'd2048);
		send(REQ_READ, 16'h0000, 16'h0000, 12'd0);
		send(REQ_READ, 16'h0000, 16'h0000, 12'd4095);
		send(REQ_READ, 16'h0000, 16'h0000, 12'd2048);

		// Random: most samples land in a few pixels so reads carry real sums.
		for (int i = 0; i < 600; i++) begin
			if (i == 200) begin
				// Drain, then hold off the sink while reads pile up.
				s_tvalid <= 1'b0;
				wait (reads_pending == 0);
				@(negedge clk);
				hold_sink = 1'b1;
				for (int j = 0; j < 12; j++)
					send(REQ_READ, 16'($urandom), 16'($urandom), 12'($urandom_range(0, 7)));
			end
			pix = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 7));
			send($urandom_range(0, 3) == 0 ? REQ_READ : REQ_ACC, 16'($urandom),
				16'($urandom), pix);
		end
		for (int p = 0; p < 8; p++) send(REQ_READ, 16'($urandom), 16'($urandom), 12'(p));
		s_tvalid <= 1'b0;

		wait (reads_pending == 0);
		repeat (100) @(posedge clk);
		if (failures == 0)
			$display("tb_polarization_angle_pixel_binner passed");
		else
			$display("tb_polarization_angle_pixel_binner failed");
		$finish;
	end

endmodule
